// ===== rtl/core/bsa_pkg.sv =====
// Package for the bitmap slot allocator: widths, command codes and shared types.
// No dependencies; the interfaces, the word evaluator and the top level import it.
`timescale 1ns / 1ps

package bsa_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int WORD_W    = 8;
  localparam int NUM_WORDS = MAX_SLOTS / WORD_W;
  localparam int WADDR_W   = $clog2(NUM_WORDS);
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int POP_W     = $clog2(WORD_W + 1);
  localparam int SLOT_W    = 6;
  localparam int CAP_W     = 7;
  localparam int CNT_W     = 7;
  localparam int CMD_W     = 3;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MARK    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot;
  } cmd_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic              found;
    logic              slot_free;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  free_count;
    logic              range_error;
  } res_word_t;

  // Summary of one bitmap word, restricted to the active slots.
  typedef struct packed {
    logic [POP_W-1:0] pop;
    logic             any_free;
    logic [BIT_W-1:0] pos;
  } eval_t;

endpackage

// ===== rtl/core/bsa_cmd_if.sv =====
// Request channel of the slot allocator: valid/ready plus one command word.
// Depends on bsa_pkg.
`timescale 1ns / 1ps

interface bsa_cmd_if import bsa_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/bsa_res_if.sv =====
// Result channel of the slot allocator: valid/ready plus one result word.
// Depends on bsa_pkg.
`timescale 1ns / 1ps

interface bsa_res_if import bsa_pkg::*; ();
  logic      valid;
  logic      ready;
  res_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/bsa_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps

module bsa_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bsa_word_eval.sv =====
// Evaluates one bitmap word: used count and lowest free bit among active slots.
// Depends on bsa_pkg.
`timescale 1ns / 1ps

module bsa_word_eval import bsa_pkg::*; (
  input  logic [WORD_W-1:0]  word_i,
  input  logic [WADDR_W-1:0] widx_i,
  input  logic [CAP_W-1:0]   cap_i,
  output eval_t              eval_o
);

  logic [WORD_W-1:0] active;
  logic [WORD_W-1:0] used_bits;
  logic [WORD_W-1:0] free_bits;

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      active[j] = ({1'b0, widx_i, BIT_W'(j)} < cap_i);
    end
    used_bits = word_i & active;
    free_bits = ~word_i & active;

    eval_o.pop = '0;
    for (int j = 0; j < WORD_W; j++) begin
      eval_o.pop = eval_o.pop + POP_W'(used_bits[j]);
    end

    // lowest free bit wins
    eval_o.pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        eval_o.pos = BIT_W'(j);
      end
    end
    eval_o.any_free = |free_bits;
  end

endmodule

// ===== rtl/core/bitmap_slot_allocator.sv =====
// Top level of the bitmap slot allocator: control sequencer, bitmap RAM, word evaluator.
// Depends on bsa_pkg, bsa_cmd_if, bsa_res_if, bsa_ram and bsa_word_eval.
`timescale 1ns / 1ps
//
//  channel   | direction | handshake        | word
//  ----------+-----------+------------------+----------------------------------
//  in_if     | in        | valid/ready      | command, slot
//  out_if    | out       | valid/ready      | slot_out, found, slot_free,
//            |           |                  | used_count, free_count, range_error
//  cfg_*     | in        | cfg_we only      | active_slots (7 bits)
//
//  Sequence: clear writes zeros to the 8 RAM words, then passes through the
//  apply state and into the output register;
//  every other command makes a read sweep over the 8 RAM
//  words (one word per cycle, registered read), then a modify/write step
//  and a step into the output register. The single RAM read port sets this pace.
//  Reset: after rst_n the sequencer sweeps zeros through all NUM_WORDS (8)
//  bitmap RAM words with in_if.ready low; cfg writes are taken throughout.
//  Stalls: a finished result sits in the output register while the next
//  request is accepted; a new result waits only if that register is still full.

module bitmap_slot_allocator import bsa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  bsa_cmd_if.sink          in_if,
  bsa_res_if.source        out_if,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_CLR   = 3'd3;
  localparam logic [2:0] ST_APPLY = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  // Control state
  logic [2:0]         state_r, state_nxt;
  logic [WADDR_W:0]   cnt_r, cnt_nxt;       // sweep counter, reaches NUM_WORDS
  logic [CAP_W-1:0]   active_r;             // active_slots register
  logic               out_valid_r, out_valid_nxt;
  logic               found_r, found_nxt;

  // Payload state
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [CNT_W-1:0]   acc_r, acc_nxt;       // used slots seen by the sweep
  logic [SLOT_W-1:0]  gidx_r, gidx_nxt;     // first free slot
  logic [WORD_W-1:0]  gword_r, gword_nxt;   // word holding the first free slot
  logic [WORD_W-1:0]  tword_r, tword_nxt;   // word holding the addressed slot
  res_word_t          res_r, res_nxt;
  res_word_t          out_data_r, out_data_nxt;

  // RAM port
  logic               ram_we;
  logic [WADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [WADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  logic [CAP_W-1:0]   cap;
  logic [WADDR_W-1:0] eidx;
  eval_t              ev;
  logic               in_fire;

  logic [BIT_W-1:0]   sbit;
  logic [WORD_W-1:0]  smask;
  logic               old_bit;
  logic               in_range;
  logic [CNT_W-1:0]   used_new;

  assign cap = (active_r > CAP_W'(MAX_SLOTS)) ? CAP_W'(MAX_SLOTS) : active_r;

  assign in_if.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // word being evaluated in the sweep arrives in the cycle after its read
  assign eidx = WADDR_W'(cnt_r - 1'b1);

  bsa_ram #(
    .DATA_W (WORD_W),
    .DEPTH  (NUM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bsa_word_eval u_eval (
    .word_i (ram_rdata),
    .widx_i (eidx),
    .cap_i  (cap),
    .eval_o (ev)
  );

  // slot addressed by release / mark / query
  assign sbit     = slot_r[BIT_W-1:0];
  assign smask    = WORD_W'(1) << sbit;
  assign old_bit  = tword_r[sbit];
  assign in_range = ({1'b0, slot_r} < cap);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    cmd_nxt       = cmd_r;
    slot_nxt      = slot_r;
    acc_nxt       = acc_r;
    gidx_nxt      = gidx_r;
    gword_nxt     = gword_r;
    tword_nxt     = tword_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    used_new      = acc_r;

    ram_we    = 1'b0;
    ram_waddr = cnt_r[WADDR_W-1:0];
    ram_wdata = '0;
    ram_raddr = cnt_r[WADDR_W-1:0];

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_INIT: begin
        // zero sweep after reset
        ram_we = 1'b1;
        if (cnt_r == (WADDR_W+1)'(NUM_WORDS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_if.data.command;
          slot_nxt  = in_if.data.slot;
          cnt_nxt   = '0;
          acc_nxt   = '0;
          found_nxt = 1'b0;
          gidx_nxt  = '0;
          state_nxt = (in_if.data.command == CMD_CLEAR) ? ST_CLR : ST_SCAN;
        end
      end

      ST_CLR: begin
        ram_we = 1'b1;
        if (cnt_r == (WADDR_W+1)'(NUM_WORDS - 1)) begin
          state_nxt = ST_APPLY;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_SCAN: begin
        // read word cnt, evaluate word cnt-1
        if (cnt_r != '0) begin
          acc_nxt = acc_r + CNT_W'(ev.pop);
          if (!found_r && ev.any_free) begin
            found_nxt = 1'b1;
            gidx_nxt  = {eidx, ev.pos};
            gword_nxt = ram_rdata;
          end
          if (eidx == slot_r[SLOT_W-1:BIT_W]) begin
            tword_nxt = ram_rdata;
          end
        end
        if (cnt_r == (WADDR_W+1)'(NUM_WORDS)) begin
          state_nxt = ST_APPLY;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_APPLY: begin
        res_nxt = '0;
        case (cmd_r)
          CMD_ALLOC: begin
            if (found_r) begin
              ram_we           = 1'b1;
              ram_waddr        = gidx_r[SLOT_W-1:BIT_W];
              ram_wdata        = gword_r | (WORD_W'(1) << gidx_r[BIT_W-1:0]);
              used_new         = acc_r + CNT_W'(1);
              res_nxt.slot_out = gidx_r;
              res_nxt.found    = 1'b1;
            end
          end
          CMD_RELEASE: begin
            if (!in_range) begin
              res_nxt.range_error = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = slot_r[SLOT_W-1:BIT_W];
              ram_wdata = tword_r & ~smask;
              used_new  = acc_r - CNT_W'(old_bit);
            end
          end
          CMD_MARK: begin
            if (!in_range) begin
              res_nxt.range_error = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = slot_r[SLOT_W-1:BIT_W];
              ram_wdata = tword_r | smask;
              used_new  = acc_r + CNT_W'(!old_bit);
            end
          end
          CMD_QUERY: begin
            if (!in_range) begin
              res_nxt.range_error = 1'b1;
            end else begin
              res_nxt.slot_free = !old_bit;
            end
          end
          default: begin
            // clear (bitmap already zeroed, acc is zero) and unused codes
          end
        endcase
        res_nxt.used_count = used_new;
        res_nxt.free_count = cap - used_new;
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      active_r    <= CAP_W'(64);
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    slot_r     <= slot_nxt;
    acc_r      <= acc_nxt;
    gidx_r     <= gidx_nxt;
    gword_r    <= gword_nxt;
    tword_r    <= tword_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  // a grant never comes with a range error
  a_grant_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> !(out_if.data.found && out_if.data.range_error))
    else $error("grant reported together with range error");

  // counts never exceed the bitmap size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |->
      ({1'b0, out_if.data.used_count} + {1'b0, out_if.data.free_count}
       <= (CNT_W+1)'(MAX_SLOTS)))
    else $error("used plus free count exceeds slot total");

  // the bitmap is only written while a request or the init sweep is running
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r != ST_IDLE && state_r != ST_OUT))
    else $error("bitmap write outside of a request");

  // an accepted request always starts a sweep
  a_accept_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_SCAN || state_r == ST_CLR))
    else $error("accepted request did not start a sweep");
`endif

endmodule
